/* design/sha_pkg.sv */
// sha_pkg: shared types, constants and functions of the SHA-256 stream hasher
// round constants, initial hash values and the sigma functions
// no dependencies
`default_nettype none

package sha_pkg;

    localparam int WORDS_PER_BLOCK = 16;
    localparam int CHAIN_WORDS     = 8;
    localparam int ROUNDS          = 64;

    localparam logic [7:0] PAD_MARK   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] LAST_FILL  = 6'd63;

    // control from the sequencer to the round datapath
    typedef struct packed {
        logic       shift_in;
        logic       do_round;
        logic [5:0] rnd;
    } sha_rctl_t;

    function automatic logic [31:0] sha_k(input logic [5:0] idx);
        logic [31:0] k;
        case (idx)
            6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
            6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
            6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
            6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
            6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
            6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
            6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
            6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
            6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
            6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
            6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
            6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
            6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
            6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
            6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
            6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
            6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
            6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
            6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
            6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
            6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
            6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
            6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
            default: k = 32'h0;
        endcase
        return k;
    endfunction

    function automatic logic [31:0] sha_iv(input logic [2:0] idx);
        logic [31:0] v;
        case (idx)
            3'd0: v = 32'h6a09e667;
            3'd1: v = 32'hbb67ae85;
            3'd2: v = 32'h3c6ef372;
            3'd3: v = 32'ha54ff53a;
            3'd4: v = 32'h510e527f;
            3'd5: v = 32'h9b05688c;
            3'd6: v = 32'h1f83d9ab;
            3'd7: v = 32'h5be0cd19;
            default: v = 32'h0;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rotr(input logic [31:0] v, input int n);
        logic [63:0] d;
        d = {v, v} >> n;
        return d[31:0];
    endfunction

    function automatic logic [31:0] big_sig0(input logic [31:0] x);
        return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sig1(input logic [31:0] x);
        return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] sml_sig0(input logic [31:0] x);
        return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] sml_sig1(input logic [31:0] x);
        return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

`default_nettype wire

/* design/sha_wbuf.sv */
// sha_wbuf: block buffer, 16 x 32-bit memory with a byte packer in front
// bytes enter big-endian; registered read port for the message schedule
// depends on sha_pkg
`default_nettype none

module sha_wbuf
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        wr_en,
    input  wire logic [7:0]  wr_byte,
    input  wire logic [5:0]  fill,
    input  wire logic        rd_en,
    input  wire logic [3:0]  rd_addr,
    output logic [31:0]      rd_word
);

    logic [31:0] mem [WORDS_PER_BLOCK];
    logic [23:0] pack_reg;
    logic [31:0] rdata_reg;

    // fourth byte of a word completes it
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            pack_reg <= {pack_reg[15:0], wr_byte};
            if (fill[1:0] == 2'd3)
            begin
                mem[fill[5:2]] <= {pack_reg, wr_byte};
            end
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
        end
    end

    assign rd_word = rdata_reg;

endmodule

`default_nettype wire

/* design/sha_chain.sv */
// sha_chain: chaining state memory, 8 x 32 bits, registered read
// per-entry valid bits make unwritten entries read as the initial hash
// depends on sha_pkg
`default_nettype none

module sha_chain
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        rd_en,
    input  wire logic [2:0]  rd_addr,
    output logic [31:0]      rd_data,
    input  wire logic        wr_en,
    input  wire logic [2:0]  wr_addr,
    input  wire logic [31:0] wr_data,
    input  wire logic        clr
);

    logic [31:0]            mem [CHAIN_WORDS];
    logic [CHAIN_WORDS-1:0] valid_reg;
    logic [31:0]            rdata_reg;
    logic                   rvld_reg;
    logic [2:0]             raddr_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clr)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[rd_addr];
            rvld_reg  <= valid_reg[rd_addr];
            raddr_reg <= rd_addr;
        end
    end

    assign rd_data = rvld_reg ? rdata_reg : sha_iv(raddr_reg);

endmodule

`default_nettype wire

/* design/sha_round.sv */
// sha_round: working variables a..h, message schedule shift line, one round per cycle
// working variables load by shifting in at h and unload by shifting out at a
// depends on sha_pkg
`default_nettype none

module sha_round
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire sha_rctl_t   ctl,
    input  wire logic [31:0] din,
    input  wire logic [31:0] buf_word,
    output logic [31:0]      wk0
);

    logic [31:0] wk_reg [CHAIN_WORDS];
    logic [31:0] w_reg  [WORDS_PER_BLOCK];
    logic [31:0] sched;
    logic [31:0] wt;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] ch;
    logic [31:0] maj;

    // w_reg[0] is w[t-16], w_reg[15] is w[t-1]
    assign sched = w_reg[0] + sml_sig0(w_reg[1]) + w_reg[9] + sml_sig1(w_reg[14]);
    assign wt    = (ctl.rnd[5:4] == 2'd0) ? buf_word : sched;

    assign ch  = (wk_reg[4] & wk_reg[5]) ^ (~wk_reg[4] & wk_reg[6]);
    assign maj = (wk_reg[0] & wk_reg[1]) ^ (wk_reg[0] & wk_reg[2]) ^ (wk_reg[1] & wk_reg[2]);
    assign t1  = wk_reg[7] + big_sig1(wk_reg[4]) + ch + sha_k(ctl.rnd) + wt;
    assign t2  = big_sig0(wk_reg[0]) + maj;

    always_ff @(posedge clk)
    begin
        if (ctl.shift_in)
        begin
            for (int i = 0; i < CHAIN_WORDS - 1; i++)
            begin
                wk_reg[i] <= wk_reg[i+1];
            end
            wk_reg[CHAIN_WORDS-1] <= din;
        end
        else if (ctl.do_round)
        begin
            wk_reg[7] <= wk_reg[6];
            wk_reg[6] <= wk_reg[5];
            wk_reg[5] <= wk_reg[4];
            wk_reg[4] <= wk_reg[3] + t1;
            wk_reg[3] <= wk_reg[2];
            wk_reg[2] <= wk_reg[1];
            wk_reg[1] <= wk_reg[0];
            wk_reg[0] <= t1 + t2;
        end
        if (ctl.do_round)
        begin
            for (int i = 0; i < WORDS_PER_BLOCK - 1; i++)
            begin
                w_reg[i] <= w_reg[i+1];
            end
            w_reg[WORDS_PER_BLOCK-1] <= wt;
        end
    end

    assign wk0 = wk_reg[0];

endmodule

`default_nettype wire

/* design/sha256_stream_hasher.sv */
// sha256_stream_hasher: top level, sequencer, padding, bit counter, digest output register
// instantiates sha_wbuf, sha_chain and sha_round
// depends on sha_pkg
`default_nettype none

// channel   direction  handshake          payload
// input     in         in_valid/in_stall  data_byte, byte_present, end_of_message
// output    out        out_valid/out_stall digest_word, word_index, last_word
//
// in_stall rises only once a block fills or end_of_message arrives, and holds
// through compression, padding and digest output
// a block stalls the input to load a..h from chain memory, run 64 rounds (one
// per cycle, one shared round unit) and fold back into chain memory
// padding writes one byte per cycle except while a filled block is compressed; each
// digest word waits only on out_stall; reset clears control and the chain valid marks
module sha256_stream_hasher
    import sha_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  data_byte,
    input  wire logic        byte_present,
    input  wire logic        end_of_message,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [31:0]      digest_word,
    output logic [2:0]       word_index,
    output logic             last_word
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_PAD,
        S_LOAD,
        S_ROUND,
        S_FOLD,
        S_ORD,
        S_OWR
    } state_t;

    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    logic [5:0]  fill_reg, fill_next;
    logic [63:0] bits_reg, bits_next;
    logic [3:0]  cnt_reg, cnt_next;
    logic [5:0]  rnd_reg, rnd_next;
    logic        first_reg, first_next;
    logic        lenst_reg, lenst_next;
    logic [2:0]  lidx_reg, lidx_next;
    logic [2:0]  widx_reg, widx_next;
    logic        outv_reg, outv_next;
    logic [31:0] oword_reg, oword_next;
    logic [2:0]  oidx_reg, oidx_next;
    logic        olast_reg, olast_next;

    logic        accept;
    logic        put_en;
    logic [7:0]  put_byte;
    logic        lenph;
    logic        full;
    logic        out_free;
    logic        ch_rd_en;
    logic [2:0]  ch_rd_addr;
    logic [31:0] ch_rd_data;
    logic        ch_wr_en;
    logic        ch_clr;
    logic        buf_rd_en;
    logic [3:0]  buf_rd_addr;
    logic [31:0] buf_word;
    logic [31:0] wk0;
    sha_rctl_t   rctl;

    assign accept   = in_valid && (state_reg == S_IDLE);
    assign out_free = !outv_reg || !out_stall;

    // padding: marker byte once, zeros to byte 56, then the length msb first
    assign lenph = !first_reg && (lenst_reg || (fill_reg == LEN_OFFSET));

    always_comb
    begin
        put_en   = 1'b0;
        put_byte = data_byte;
        case (state_reg)
            S_IDLE:
            begin
                put_en = accept && byte_present;
            end
            S_PAD:
            begin
                put_en = 1'b1;
                if (first_reg)
                begin
                    put_byte = PAD_MARK;
                end
                else if (lenph)
                begin
                    put_byte = bits_reg[{~lidx_reg, 3'b000} +: 8];
                end
                else
                begin
                    put_byte = 8'h00;
                end
            end
            default:
            begin
                put_en = 1'b0;
            end
        endcase
    end

    assign full = put_en && (fill_reg == LAST_FILL);

    // chain memory and buffer access per state
    always_comb
    begin
        ch_rd_en    = 1'b0;
        ch_rd_addr  = cnt_reg[2:0];
        ch_wr_en    = 1'b0;
        buf_rd_en   = 1'b0;
        buf_rd_addr = rnd_reg[3:0] + 4'd1;
        rctl        = '{shift_in: 1'b0, do_round: 1'b0, rnd: rnd_reg};
        case (state_reg)
            S_LOAD:
            begin
                ch_rd_en      = !cnt_reg[3];
                rctl.shift_in = (cnt_reg != 4'd0);
                buf_rd_en     = cnt_reg[3];
                buf_rd_addr   = 4'd0;
            end
            S_ROUND:
            begin
                rctl.do_round = 1'b1;
                buf_rd_en     = (rnd_reg[5:4] == 2'd0);
            end
            S_FOLD:
            begin
                ch_rd_en      = !cnt_reg[3];
                ch_wr_en      = (cnt_reg != 4'd0);
                rctl.shift_in = (cnt_reg != 4'd0);
            end
            S_ORD:
            begin
                ch_rd_en   = 1'b1;
                ch_rd_addr = widx_reg;
            end
            default:
            begin
                ch_rd_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        fill_next  = put_en ? fill_reg + 6'd1 : fill_reg;
        bits_next  = bits_reg;
        cnt_next   = cnt_reg;
        rnd_next   = rnd_reg;
        first_next = first_reg;
        lenst_next = lenst_reg;
        lidx_next  = lidx_reg;
        widx_next  = widx_reg;
        outv_next  = outv_reg && out_stall;
        oword_next = oword_reg;
        oidx_next  = oidx_reg;
        olast_next = olast_reg;
        ch_clr     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (byte_present)
                    begin
                        bits_next = bits_reg + 64'd8;
                    end
                    if (end_of_message)
                    begin
                        first_next = 1'b1;
                        lenst_next = 1'b0;
                        lidx_next  = 3'd0;
                    end
                    if (full)
                    begin
                        state_next = S_LOAD;
                        cnt_next   = 4'd0;
                        ret_next   = end_of_message ? S_PAD : S_IDLE;
                    end
                    else if (end_of_message)
                    begin
                        state_next = S_PAD;
                    end
                end
            end
            S_PAD:
            begin
                first_next = 1'b0;
                if (lenph)
                begin
                    lenst_next = 1'b1;
                    lidx_next  = lidx_reg + 3'd1;
                end
                if (full)
                begin
                    state_next = S_LOAD;
                    cnt_next   = 4'd0;
                    ret_next   = (lenph && (lidx_reg == 3'd7)) ? S_ORD : S_PAD;
                    widx_next  = 3'd0;
                end
            end
            S_LOAD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg[3])
                begin
                    state_next = S_ROUND;
                    rnd_next   = 6'd0;
                end
            end
            S_ROUND:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'(ROUNDS - 1))
                begin
                    state_next = S_FOLD;
                    cnt_next   = 4'd0;
                end
            end
            S_FOLD:
            begin
                cnt_next = cnt_reg + 4'd1;
                if (cnt_reg[3])
                begin
                    state_next = ret_reg;
                end
            end
            S_ORD:
            begin
                state_next = S_OWR;
            end
            S_OWR:
            begin
                if (out_free)
                begin
                    outv_next  = 1'b1;
                    oword_next = ch_rd_data;
                    oidx_next  = widx_reg;
                    olast_next = (widx_reg == 3'd7);
                    widx_next  = widx_reg + 3'd1;
                    if (widx_reg == 3'd7)
                    begin
                        // back to initial hash for the next message
                        ch_clr     = 1'b1;
                        bits_next  = 64'd0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_ORD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ret_reg   <= S_IDLE;
            fill_reg  <= 6'd0;
            bits_reg  <= 64'd0;
            cnt_reg   <= 4'd0;
            rnd_reg   <= 6'd0;
            first_reg <= 1'b0;
            lenst_reg <= 1'b0;
            lidx_reg  <= 3'd0;
            widx_reg  <= 3'd0;
            outv_reg  <= 1'b0;
            oword_reg <= 32'd0;
            oidx_reg  <= 3'd0;
            olast_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            fill_reg  <= fill_next;
            bits_reg  <= bits_next;
            cnt_reg   <= cnt_next;
            rnd_reg   <= rnd_next;
            first_reg <= first_next;
            lenst_reg <= lenst_next;
            lidx_reg  <= lidx_next;
            widx_reg  <= widx_next;
            outv_reg  <= outv_next;
            oword_reg <= oword_next;
            oidx_reg  <= oidx_next;
            olast_reg <= olast_next;
        end
    end

    sha_wbuf u_wbuf (
        .clk     (clk),
        .wr_en   (put_en),
        .wr_byte (put_byte),
        .fill    (fill_reg),
        .rd_en   (buf_rd_en),
        .rd_addr (buf_rd_addr),
        .rd_word (buf_word)
    );

    sha_chain u_chain (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (ch_rd_en),
        .rd_addr (ch_rd_addr),
        .rd_data (ch_rd_data),
        .wr_en   (ch_wr_en),
        .wr_addr (3'(cnt_reg - 4'd1)),
        .wr_data (ch_rd_data + wk0),
        .clr     (ch_clr)
    );

    sha_round u_round (
        .clk      (clk),
        .ctl      (rctl),
        .din      (ch_rd_data),
        .buf_word (buf_word),
        .wk0      (wk0)
    );

    assign in_stall    = (state_reg != S_IDLE);
    assign out_valid   = outv_reg;
    assign digest_word = oword_reg;
    assign word_index  = oidx_reg;
    assign last_word   = olast_reg;

    // last flag marks exactly the eighth word
    a_last_idx: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word does not match word_index");

    // the digest is read only after padding has closed the final block
    a_out_fill: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ORD) |-> (fill_reg == 6'd0))
        else $error("digest read with a partly filled block");

    // the last round hands over to the fold
    a_rnd_end: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROUND && rnd_reg == 6'd63) |=> (state_reg == S_FOLD))
        else $error("round sequence overran");

    // a block fills only while no compression is under way
    a_put_state: assert property (@(posedge clk) disable iff (!rst_n)
        put_en |-> (state_reg == S_IDLE || state_reg == S_PAD))
        else $error("byte written during compression");

endmodule

`default_nettype wire
